FILE: hdl/first_substring_match_finder_assert.svh
// ----------------------------------------------------------------------------
// first_substring_match_finder assertion macros
// Shared concurrent assertion forms for the substring finder RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_SUBSTRING_MATCH_FINDER_ASSERT_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_ASSERT_SVH

// same-cycle implication
`define FSMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsmf assertion failed");

// next-cycle implication
`define FSMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsmf assertion failed");

`endif

FILE: hdl/fsmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_pkg
// Types and constants shared by the substring finder modules.
// ----------------------------------------------------------------------------
package fsmf_pkg;

	localparam int NLEN_W  = 5;
	localparam int CNT_W   = 31;
	localparam int WORD_W  = 64;
	localparam int REG_IDX_W = 2;
	localparam int OFS_W   = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

	localparam logic signed [OFS_W-1:0] NOT_FOUND = -32'sd1;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       carries_byte;
		logic       end_of_text;
	} fsmf_in_t;

	typedef struct packed {
		logic                    found;
		logic signed [OFS_W-1:0] match_offset;
	} fsmf_out_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] index;
		logic [WORD_W-1:0]    data;
	} fsmf_cfg_t;

	// control shared by every cell of the window
	typedef struct packed {
		logic              shift;
		logic [NLEN_W-1:0] used_len;
	} fsmf_cell_ctl_t;

endpackage

FILE: hdl/fsmf_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fsmf_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/first_substring_match_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_substring_match_finder
// Streaming first-occurrence substring search over a row of window cells.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (needle low word, needle high word, needle length),
//            always ready; write only while no haystack is in flight.
//   text   - one haystack byte per transaction; carries_byte=0 with
//            end_of_text=1 closes a haystack without adding a byte.
//   result - one transaction per end_of_text transaction: found flag and
//            first match offset, -1 when absent, 0 for an empty needle.
// Throughput is one text transaction per cycle while result is not stalled: all
// window cells compare in parallel in the cycle the byte arrives, and the match
// latch updates there. result.valid rises in the cycle after the end transaction,
// set by the output register. While result is stalled text is held off; the
// output register frees the same cycle the receiver takes the result.
// Reset clears the needle registers, the position count, the match latch and
// the output valid. After each result the scan state clears for a new haystack.
// ----------------------------------------------------------------------------
module first_substring_match_finder #(
	parameter int MAX_NEEDLE_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	fsmf_chan_if.sink    cfg,
	fsmf_chan_if.sink    text,
	fsmf_chan_if.source  result
);
	import fsmf_pkg::*;

	logic [WORD_W-1:0] needle_lo_q;
	logic [WORD_W-1:0] needle_hi_q;
	logic [NLEN_W-1:0] needle_len_q;

	logic [CNT_W-1:0]  seen_q;
	logic              latched_q;
	logic [CNT_W-1:0]  first_offset_q;

	logic              res_valid_q;
	fsmf_out_t         res_q;

	logic [NLEN_W-1:0] used_len;
	logic [7:0]        needle_bytes [MAX_NEEDLE_BYTES];
	logic [7:0]        chain_in [MAX_NEEDLE_BYTES];
	logic [7:0]        cell_byte [MAX_NEEDLE_BYTES];
	logic [MAX_NEEDLE_BYTES-1:0] hits;
	fsmf_cell_ctl_t    ctl;

	logic              text_acc;
	logic              take_byte;
	logic              counted;
	logic [CNT_W-1:0]  seen_inc;
	logic [CNT_W-1:0]  len_ext;
	logic              new_match;
	logic              next_latched;
	logic [CNT_W-1:0]  next_offset;
	fsmf_out_t         res_d;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q  <= '0;
			needle_hi_q  <= '0;
			needle_len_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_NEEDLE_LOW:  needle_lo_q  <= cfg.payload.data;
				REG_NEEDLE_HIGH: needle_hi_q  <= cfg.payload.data;
				REG_NEEDLE_LEN:  needle_len_q <= cfg.payload.data[NLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign used_len = (needle_len_q > NLEN_W'(MAX_NEEDLE_BYTES)) ?
		NLEN_W'(MAX_NEEDLE_BYTES) : needle_len_q;

	// window of cells, cell 0 holds the newest byte
	assign text_acc  = text.valid && text.ready;
	assign take_byte = text_acc && text.payload.carries_byte;
	assign ctl.shift    = take_byte;
	assign ctl.used_len = used_len;

	for (genvar k = 0; k < MAX_NEEDLE_BYTES; k++) begin : g_cell
		if (k < 8) begin : g_lo
			assign needle_bytes[k] = needle_lo_q[8*k +: 8];
		end else begin : g_hi
			assign needle_bytes[k] = needle_hi_q[8*(k-8) +: 8];
		end

		if (k == 0) begin : g_head
			assign chain_in[k] = text.payload.text_byte;
		end else begin : g_body
			assign chain_in[k] = cell_byte[k-1];
		end

		fsmf_cell #(
			.MAX_NEEDLE_BYTES(MAX_NEEDLE_BYTES),
			.INDEX(k)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.byte_in(chain_in[k]),
			.needle(needle_bytes),
			.byte_q(cell_byte[k]),
			.hit(hits[k])
		);
	end

	// position count and first-match latch
	assign counted  = seen_q != CNT_MAX;
	assign seen_inc = seen_q + CNT_W'(1);
	assign len_ext  = CNT_W'(used_len);

	assign new_match = take_byte && counted && !latched_q && (used_len != '0) &&
		(seen_inc >= len_ext) && (&hits);
	assign next_latched = latched_q || new_match;
	assign next_offset  = new_match ? (seen_inc - len_ext) : first_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= '0;
			latched_q      <= 1'b0;
			first_offset_q <= '0;
		end else if (text_acc && text.payload.end_of_text) begin
			seen_q         <= '0;
			latched_q      <= 1'b0;
			first_offset_q <= '0;
		end else if (take_byte && counted) begin
			seen_q         <= seen_inc;
			latched_q      <= next_latched;
			first_offset_q <= next_offset;
		end
	end

	// result register
	always_comb begin
		if (used_len == '0) begin
			res_d.found        = 1'b1;
			res_d.match_offset = '0;
		end else if (next_latched) begin
			res_d.found        = 1'b1;
			res_d.match_offset = {1'b0, next_offset};
		end else begin
			res_d.found        = 1'b0;
			res_d.match_offset = NOT_FOUND;
		end
	end

	assign text.ready = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (text_acc && text.payload.end_of_text) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc && text.payload.end_of_text) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// checks
	`include "first_substring_match_finder_assert.svh"

	`FSMF_ASSERT_NEXT(a_latch_holds, clk, arst_n,
		latched_q && !(text_acc && text.payload.end_of_text), latched_q)
	`FSMF_ASSERT_NEXT(a_clear_after_end, clk, arst_n,
		text_acc && text.payload.end_of_text, (seen_q == '0) && !latched_q)
	`FSMF_ASSERT_NOW(a_miss_offset, clk, arst_n,
		res_valid_q && !res_q.found, res_q.match_offset == NOT_FOUND)

endmodule

FILE: hdl/fsmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_cell
// One window byte: shifts toward the older end and compares the byte it
// takes in against its needle byte.
// ----------------------------------------------------------------------------
module fsmf_cell #(
	parameter int MAX_NEEDLE_BYTES = 16,
	parameter int INDEX = 0
) (
	input  logic                    clk,
	input  fsmf_pkg::fsmf_cell_ctl_t ctl,
	input  logic [7:0]              byte_in,
	input  logic [7:0]              needle [MAX_NEEDLE_BYTES],
	output logic [7:0]              byte_q,
	output logic                    hit
);
	import fsmf_pkg::*;

	localparam int IDX_W = (MAX_NEEDLE_BYTES > 1) ? $clog2(MAX_NEEDLE_BYTES) : 1;

	logic              active;
	logic [NLEN_W-1:0] sel_full;
	logic [IDX_W-1:0]  sel;

	// cell k lines up with needle byte used_len-1-k
	assign active   = NLEN_W'(INDEX) < ctl.used_len;
	assign sel_full = ctl.used_len - NLEN_W'(1) - NLEN_W'(INDEX);
	assign sel      = sel_full[IDX_W-1:0];
	assign hit      = !active || (byte_in == needle[sel]);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

endmodule
